@@ rtl/fru_pkg.sv @@
// Shared types for the fraction reducer: control state and divider handshake structs.
package fru_pkg;

    // Control sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVN = 5'b00100,
        S_DIVD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // Request into the shared serial divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status back from the shared serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/fru_in_if.sv @@
// Input request channel of the fraction reducer: valid/ready plus the fraction.
interface fru_in_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] numerator;
    logic [VALUE_WIDTH-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

@@ rtl/fru_out_if.sv @@
// Result channel of the fraction reducer: valid/ready plus the reduced fraction.
interface fru_out_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] reduced_numerator;
    logic [VALUE_WIDTH-1:0] reduced_denominator;
    logic                   bad_input;

    modport source (output valid, output reduced_numerator, output reduced_denominator,
                    output bad_input, input ready);
    modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                    input bad_input, output ready);
endinterface

@@ rtl/fru_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, quotient and remainder.
module fru_divider #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fru_pkg::t_div_ctl      i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output fru_pkg::t_div_stat     o_stat,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   rem_diff;
    logic                   fits;

    // Shift the next dividend bit into the partial remainder and trial-subtract
    assign rem_sh   = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign fits     = (rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            // Load operands, clear the partial remainder
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(VALUE_WIDTH - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Advance one quotient bit
            n_quo = {r_quo[VALUE_WIDTH-2:0], fits};
            n_rem = fits ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // A finished division leaves a remainder below the divisor
    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    // Done follows the last step of a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    // A new start never lands on a running division
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider started while busy");
endmodule

@@ rtl/fraction_reducer_unit.sv @@
// Top level of the fraction reducer: Euclid sequencer over a serial divider, result register.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------------
//  i_req    | in  | valid / ready  | numerator, denominator
//  o_res    | out | valid / ready  | reduced_numerator, reduced_denominator, bad_input
//
// Each divider pass is one load followed by VALUE_WIDTH shift steps. An item runs one pass
// per Euclid remainder step (at most about 1.44 * VALUE_WIDTH steps), then one pass each to
// divide the numerator and the denominator by the gcd; a zero numerator, a unit or zero
// denominator skip the divider. All passes run on the single shared divider.
// Reset clears the sequencer, the divider control and the result valid flag.
// A new request is taken while a result waits in the output register; a finished item
// holds in S_DONE until that register is free.
module fraction_reducer_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fru_in_if.sink   i_req,
    fru_out_if.source o_res
);
    fru_pkg::t_state r_state, n_state;

    logic [VALUE_WIDTH-1:0] r_num, n_num;
    logic [VALUE_WIDTH-1:0] r_den, n_den;
    logic [VALUE_WIDTH-1:0] r_b, n_b;
    logic [VALUE_WIDTH-1:0] r_g, n_g;
    logic [VALUE_WIDTH-1:0] r_res_num, n_res_num;
    logic [VALUE_WIDTH-1:0] r_res_den, n_res_den;
    logic                   r_bad, n_bad;

    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_num, n_out_num;
    logic [VALUE_WIDTH-1:0] r_out_den, n_out_den;
    logic                   r_out_bad, n_out_bad;

    fru_pkg::t_div_ctl      div_ctl;
    fru_pkg::t_div_stat     div_stat;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_divisor;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    logic in_acc;
    logic out_free;

    assign i_req.ready = (r_state == fru_pkg::S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    fru_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Sequence: pass trivial inputs through, else gcd by repeated remainders, then divide both terms by it
    always_comb begin
        n_state       = r_state;
        n_num         = r_num;
        n_den         = r_den;
        n_b           = r_b;
        n_g           = r_g;
        n_res_num     = r_res_num;
        n_res_den     = r_res_den;
        n_bad         = r_bad;
        div_ctl.start = 1'b0;
        div_dividend  = r_b;
        div_divisor   = div_rem;
        unique case (r_state)
            fru_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_num     = i_req.numerator;
                    n_den     = i_req.denominator;
                    n_b       = i_req.denominator;
                    n_res_num = i_req.numerator;
                    n_res_den = i_req.denominator;
                    n_bad     = (i_req.denominator == '0);
                    if (i_req.denominator == '0 || i_req.numerator == '0 ||
                        i_req.denominator == VALUE_WIDTH'(1)) begin
                        // Pass through unchanged
                        n_state = fru_pkg::S_DONE;
                    end else begin
                        div_ctl.start = 1'b1;
                        div_dividend  = i_req.numerator;
                        div_divisor   = i_req.denominator;
                        n_state       = fru_pkg::S_GCD;
                    end
                end
            end
            fru_pkg::S_GCD: begin
                if (div_stat.done) begin
                    div_ctl.start = 1'b1;
                    if (div_rem == '0) begin
                        // Last divisor is the gcd: reduce the numerator
                        n_g          = r_b;
                        div_dividend = r_num;
                        div_divisor  = r_b;
                        n_state      = fru_pkg::S_DIVN;
                    end else begin
                        // Advance Euclid: b mod rem
                        n_b          = div_rem;
                        div_dividend = r_b;
                        div_divisor  = div_rem;
                    end
                end
            end
            fru_pkg::S_DIVN: begin
                if (div_stat.done) begin
                    n_res_num     = div_quo;
                    div_ctl.start = 1'b1;
                    div_dividend  = r_den;
                    div_divisor   = r_g;
                    n_state       = fru_pkg::S_DIVD;
                end
            end
            fru_pkg::S_DIVD: begin
                if (div_stat.done) begin
                    n_res_den = div_quo;
                    n_state   = fru_pkg::S_DONE;
                end
            end
            fru_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = fru_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fru_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result until the sink takes it; load when the slot frees
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_bad   = r_out_bad;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == fru_pkg::S_DONE && out_free) begin
            n_out_valid = 1'b1;
            n_out_num   = r_res_num;
            n_out_den   = r_res_den;
            n_out_bad   = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fru_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_num     <= n_num;
        r_den     <= n_den;
        r_b       <= n_b;
        r_g       <= n_g;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_bad     <= n_bad;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        r_out_bad <= n_out_bad;
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.reduced_numerator   = r_out_num;
    assign o_res.reduced_denominator = r_out_den;
    assign o_res.bad_input           = r_out_bad;

    // An accepted request always leaves the idle state
    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != fru_pkg::S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // A flagged result carries a zero denominator
    a_bad_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_den == '0))
        else $error("bad_input result with nonzero denominator");

    // The gcd used for reduction is never zero
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fru_pkg::S_DIVN || r_state == fru_pkg::S_DIVD) |-> (r_g != '0))
        else $error("reduction with zero gcd");
endmodule
